// ===== hdl/hgp_pkg.sv =====
`timescale 1ns / 1ps

package hgp_pkg;

  localparam int SLOT_COUNT_DEF = 2048;
  localparam int IDX_W = 11;
  localparam int GEN_W = 16;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_DESTROY = 2'd1;
  localparam logic [1:0] ACT_USE = 2'd2;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_BAD = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] handle_generation;
  } hgp_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] out_index;
    logic [GEN_W-1:0] out_generation;
    logic             first_use;
  } hgp_out_t;

  typedef struct packed {
    logic clr;
    logic pop;
    logic push;
  } hgp_stk_ctl_t;

  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
    logic mark;
  } hgp_slot_ctl_t;

endpackage

// ===== hdl/hgp_free_stack.sv =====
`timescale 1ns / 1ps

module hgp_free_stack import hgp_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hgp_stk_ctl_t                    ctl,
  input  logic [$clog2(SLOT_COUNT)-1:0]   clr_addr,
  input  logic [$clog2(SLOT_COUNT)-1:0]   push_slot,
  output logic                            empty,
  output logic [$clog2(SLOT_COUNT)-1:0]   top_slot
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = AW + 1;

  logic [AW-1:0] mem [SLOT_COUNT];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] count_dec;
  logic [AW-1:0] top_r;
  logic          full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;

  assign empty = (count_r == '0);
  assign full = (count_r == CW'(SLOT_COUNT));
  assign count_dec = count_r - 1'b1;
  assign top_slot = top_r;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = clr_addr;
    wr_data = clr_addr;
    count_nxt = count_r;
    if (ctl.clr) begin
      wr_en = 1'b1;
    end else if (ctl.pop && !empty) begin
      count_nxt = count_dec;
    end else if (ctl.push && !full) begin
      wr_en = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = push_slot;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(SLOT_COUNT);
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.pop && !empty) begin
      top_r <= mem[count_dec[AW-1:0]];
    end
  end

endmodule

// ===== hdl/hgp_slot_table.sv =====
`timescale 1ns / 1ps

module hgp_slot_table import hgp_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  hgp_slot_ctl_t                 ctl,
  input  logic [$clog2(SLOT_COUNT)-1:0] clr_addr,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  logic [GEN_W-1:0]              wr_gen,
  output logic [GEN_W-1:0]              rd_gen,
  output logic                          rd_mark
);

  localparam int AW = $clog2(SLOT_COUNT);

  logic [GEN_W:0]  mem [SLOT_COUNT];
  logic [GEN_W:0]  rd_r;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [GEN_W:0]  wdata;

  assign rd_gen = rd_r[GEN_W:1];
  assign rd_mark = rd_r[0];

  always_comb begin
    we = ctl.clr || ctl.wr;
    waddr = ctl.clr ? clr_addr : wr_addr;
    wdata = ctl.clr ? '0 : {wr_gen, ctl.mark};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rd_r <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/generational_handle_pool_unit.sv =====
`timescale 1ns / 1ps

// Generational handle pool. A request is transferred on in_data at a rising
// edge where start is high and busy is low. Action create pops a free slot
// and returns its new handle, destroy retires a handle and returns the slot
// to the pool, and use checks a handle and flags the first use since create.
// Each request yields exactly one result on out_data, marked by out_strobe
// for a single cycle; the receiver cannot stall, so the result is taken then.
// Steps from the accepting edge to the result and to the next accept: a
// create on an empty pool strobes in the next cycle and busy stays low; a
// create on a non-empty pool reads the free stack, then reads the slot
// record, then writes it back; destroy, use and an unknown action read the
// slot record, then destroy and use write it back if the handle is valid.
// Reads from the slot record memory and the free stack memory are
// registered. After reset the block holds busy high while it initializes
// the free stack and clears every slot record.
module generational_handle_pool_unit import hgp_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hgp_in_t  in_data,
  output logic     out_strobe,
  output hgp_out_t out_data
);

  localparam int AW = $clog2(SLOT_COUNT);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_STACK = 2'd2;
  localparam logic [1:0] S_SLOT = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  hgp_in_t       req_r, req_nxt;
  logic          in_range_r, in_range_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  hgp_out_t      out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  hgp_stk_ctl_t  stk_ctl;
  hgp_slot_ctl_t slot_ctl;
  logic          stk_empty;
  logic [AW-1:0] stk_top;
  logic [AW-1:0] rd_addr;
  logic [GEN_W-1:0] wr_gen;
  logic [GEN_W-1:0] rd_gen;
  logic          rd_mark;
  logic          accept;
  logic          in_range;
  logic [GEN_W-1:0] cur;
  logic [GEN_W-1:0] cur_inc;
  logic          valid;

  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign in_range = (32'(in_data.slot_index) < SLOT_COUNT);
  assign cur = in_range_r ? rd_gen : '0;
  assign cur_inc = cur + 1'b1;
  assign valid = in_range_r && (cur == req_r.handle_generation) && cur[0];
  assign out_strobe = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    req_nxt = req_r;
    in_range_nxt = in_range_r;
    slot_nxt = slot_r;
    out_nxt = out_r;
    out_valid_nxt = 1'b0;
    stk_ctl = '0;
    slot_ctl = '0;
    rd_addr = AW'(in_data.slot_index);
    wr_gen = cur;

    case (state_r)
      S_CLEAR: begin
        stk_ctl.clr = 1'b1;
        slot_ctl.clr = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(SLOT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          if (in_data.action == ACT_CREATE) begin
            in_range_nxt = 1'b1;
            if (stk_empty) begin
              out_nxt = '{status: STAT_EMPTY, out_index: '0, out_generation: '0,
                          first_use: 1'b0};
              out_valid_nxt = 1'b1;
            end else begin
              stk_ctl.pop = 1'b1;
              state_nxt = S_STACK;
            end
          end else begin
            in_range_nxt = in_range;
            slot_ctl.rd = in_range;
            slot_nxt = AW'(in_data.slot_index);
            state_nxt = S_SLOT;
          end
        end
      end
      S_STACK: begin
        rd_addr = stk_top;
        slot_ctl.rd = 1'b1;
        slot_nxt = stk_top;
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt = '{status: STAT_BAD, out_index: req_r.slot_index, out_generation: cur,
                    first_use: 1'b0};
        case (req_r.action)
          ACT_CREATE: begin
            wr_gen = cur_inc;
            slot_ctl.wr = 1'b1;
            out_nxt.status = STAT_OK;
            out_nxt.out_index = IDX_W'(slot_r);
            out_nxt.out_generation = cur_inc;
          end
          ACT_DESTROY: begin
            if (valid) begin
              wr_gen = cur_inc;
              slot_ctl.wr = 1'b1;
              stk_ctl.push = 1'b1;
              out_nxt.status = STAT_OK;
              out_nxt.out_generation = cur_inc;
            end
          end
          ACT_USE: begin
            if (valid) begin
              slot_ctl.wr = 1'b1;
              slot_ctl.mark = 1'b1;
              out_nxt.status = STAT_OK;
              out_nxt.first_use = !rd_mark;
            end
          end
          default: begin
            out_nxt.status = STAT_BAD;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    in_range_r <= in_range_nxt;
    slot_r <= slot_nxt;
    out_r <= out_nxt;
  end

  hgp_free_stack #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (stk_ctl),
    .clr_addr (clr_r),
    .push_slot(slot_r),
    .empty    (stk_empty),
    .top_slot (stk_top)
  );

  hgp_slot_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slots (
    .clk     (clk),
    .ctl     (slot_ctl),
    .clr_addr(clr_r),
    .rd_addr (rd_addr),
    .wr_addr (slot_r),
    .wr_gen  (wr_gen),
    .rd_gen  (rd_gen),
    .rd_mark (rd_mark)
  );

endmodule

// ===== hdl/hgp_checker.sv =====
`timescale 1ns / 1ps

module hgp_checker import hgp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input hgp_in_t  in_data,
  input logic     out_strobe,
  input hgp_out_t out_data
);

  // Every transfer either occupies the block or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted request neither started work nor answered");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.status == STAT_OK || out_data.status == STAT_EMPTY ||
                    out_data.status == STAT_BAD))
    else $error("result carries an undefined status");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == STAT_EMPTY) |->
      (out_data.out_index == '0 && out_data.out_generation == '0 && !out_data.first_use))
    else $error("empty pool result is not all zero");

  a_first_use_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.first_use) |->
      (out_data.status == STAT_OK && out_data.out_generation[0]))
    else $error("first use flagged on a rejected or free handle");

endmodule

bind generational_handle_pool_unit hgp_checker u_hgp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);

// ===== tb/generational_handle_pool_unit_tb.sv =====
`timescale 1ns / 1ps

module generational_handle_pool_unit_tb;
  import hgp_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int LIMIT_CYCLES = 100000;
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_PER_PHASE = 560;
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  hgp_in_t  in_data = '0;
  logic     out_strobe;
  hgp_out_t out_data;

  generational_handle_pool_unit #(.SLOT_COUNT(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the pool, advanced once per accepted request.
  logic [IDX_W-1:0] pool_free_stack [SLOTS];
  int               pool_free_count;
  logic [GEN_W-1:0] pool_gen [SLOTS];
  bit               pool_drawn [SLOTS];

  hgp_in_t  pending_requests [$];
  hgp_out_t pending_results [$];
  int       n_queued = 0;
  int       n_accepted = 0;
  int       idle_pct = 25;
  int       mismatches = 0;
  int       cycle_count = 0;

  function automatic hgp_out_t predict_handle_op(hgp_in_t req);
    hgp_out_t         r;
    logic [GEN_W-1:0] cur;
    logic [IDX_W-1:0] s;
    bit               in_range;
    bit               live;
    in_range = int'(req.slot_index) < SLOTS;
    cur = in_range ? pool_gen[req.slot_index] : '0;
    live = in_range && cur == req.handle_generation && cur[0];
    r.status = STAT_BAD;
    r.out_index = req.slot_index;
    r.out_generation = cur;
    r.first_use = 1'b0;
    case (req.action)
      ACT_CREATE: begin
        if (pool_free_count == 0) begin
          r.status = STAT_EMPTY;
          r.out_index = '0;
          r.out_generation = '0;
        end else begin
          pool_free_count--;
          s = pool_free_stack[pool_free_count];
          pool_gen[s] = pool_gen[s] + 1'b1;
          pool_drawn[s] = 1'b0;
          r.status = STAT_OK;
          r.out_index = s;
          r.out_generation = pool_gen[s];
        end
      end
      ACT_DESTROY: begin
        if (live) begin
          pool_gen[req.slot_index] = cur + 1'b1;
          pool_drawn[req.slot_index] = 1'b0;
          if (pool_free_count < SLOTS) begin
            pool_free_stack[pool_free_count] = req.slot_index;
            pool_free_count++;
          end
          r.status = STAT_OK;
          r.out_generation = cur + 1'b1;
        end
      end
      ACT_USE: begin
        if (live) begin
          r.first_use = !pool_drawn[req.slot_index];
          pool_drawn[req.slot_index] = 1'b1;
          r.status = STAT_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : driver
    hgp_in_t next_req;
    logic    next_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      next_req = in_data;
      if (start && !busy) begin
        pending_results.push_back(predict_handle_op(in_data));
        n_accepted++;
        next_start = 1'b0;
      end
      if (!next_start && pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_req = pending_requests.pop_front();
        next_start = 1'b1;
      end
      start <= next_start;
      in_data <= next_req;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    hgp_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with none expected, actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("out_index", 32'(want.out_index), 32'(out_data.out_index));
        check_field("out_generation", 32'(want.out_generation),
                    32'(out_data.out_generation));
        check_field("first_use", 32'(want.first_use), 32'(out_data.first_use));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** generational_handle_pool_unit: FAILED **");
      $finish;
    end
  end

  int      live_slots [$];
  hgp_in_t stale_handles [$];

  task automatic send(logic [1:0] act, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    hgp_in_t req;
    req.action = act;
    req.slot_index = idx;
    req.handle_generation = gen;
    pending_requests.push_back(req);
    n_queued++;
  endtask

  task automatic settle();
    while (n_accepted != n_queued) @(negedge clk);
  endtask

  task automatic collect_live();
    live_slots.delete();
    for (int i = 0; i < SLOTS; i++) begin
      if (pool_gen[i][0]) live_slots.push_back(i);
    end
  endtask

  // Mostly well-formed traffic on handles that are live when the batch is
  // planned, with stale handles, wrong generations and random requests mixed in.
  task automatic random_batch(int n);
    int               roll;
    int               k;
    int               s;
    logic [GEN_W-1:0] g;
    hgp_in_t          h;
    settle();
    collect_live();
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        send(ACT_CREATE, IDX_W'($urandom_range(SLOTS - 1)), GEN_W'($urandom_range(65535)));
      end else if (roll < 85 && live_slots.size() > 0) begin
        k = $urandom_range(live_slots.size() - 1);
        s = live_slots[k];
        if (roll < 62) begin
          send(ACT_DESTROY, IDX_W'(s), pool_gen[s]);
          h.action = ACT_DESTROY;
          h.slot_index = IDX_W'(s);
          h.handle_generation = pool_gen[s];
          stale_handles.push_back(h);
          if (stale_handles.size() > 64) void'(stale_handles.pop_front());
          live_slots.delete(k);
        end else begin
          send(ACT_USE, IDX_W'(s), pool_gen[s]);
        end
      end else if (roll < 92 && stale_handles.size() > 0) begin
        h = stale_handles[$urandom_range(stale_handles.size() - 1)];
        send($urandom_range(1) ? ACT_USE : ACT_DESTROY, h.slot_index, h.handle_generation);
      end else if (roll < 95 && live_slots.size() > 0) begin
        s = live_slots[$urandom_range(live_slots.size() - 1)];
        g = pool_gen[s] + GEN_W'($urandom_range(1, 65535));
        send($urandom_range(1) ? ACT_USE : ACT_DESTROY, IDX_W'(s), g);
      end else begin
        send(2'($urandom_range(3)), IDX_W'($urandom_range(SLOTS - 1)),
             GEN_W'($urandom_range(65535)));
      end
    end
  endtask

  task automatic random_phase(int total);
    int n;
    int done;
    done = 0;
    while (done < total) begin
      n = $urandom_range(8, 40);
      random_batch(n);
      done += n;
    end
  endtask

  initial begin : stimulus
    logic [IDX_W-1:0] top;
    for (int i = 0; i < SLOTS; i++) begin
      pool_free_stack[i] = IDX_W'(i);
      pool_gen[i] = '0;
      pool_drawn[i] = 1'b0;
    end
    pool_free_count = SLOTS;
    top = IDX_W'(SLOTS - 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 25;
    send(ACT_CREATE, '1, '1);
    send(ACT_USE, top, 16'd1);
    send(ACT_USE, top, 16'd1);
    send(ACT_USE, top, 16'd3);
    send(ACT_DESTROY, top, 16'hFFFF);
    send(ACT_DESTROY, top, 16'd1);
    send(ACT_DESTROY, top, 16'd1);
    send(ACT_DESTROY, top, 16'd2);
    send(ACT_USE, top, 16'd2);
    send(ACT_USE, '0, '0);
    send(ACT_UNDEFINED, top, 16'd2);
    send(ACT_UNDEFINED, '0, '1);
    send(ACT_CREATE, '0, '0);
    send(ACT_CREATE, 11'h555, 16'hAAAA);
    send(ACT_USE, top - 1'b1, 16'd1);
    send(ACT_DESTROY, top, 16'd3);
    send(ACT_CREATE, 11'h2AA, 16'h5555);
    send(ACT_USE, top, 16'd5);
    send(ACT_USE, 11'd1234, 16'h5555);
    send(ACT_DESTROY, top - 1'b1, 16'd1);
    random_phase(RANDOM_PER_PHASE);

    settle();
    idle_pct = 59;
    random_phase(RANDOM_PER_PHASE);

    settle();
    idle_pct = 0;
    random_phase(RANDOM_PER_PHASE);

    settle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("** generational_handle_pool_unit: PASSED **");
    end else begin
      $display("** generational_handle_pool_unit: FAILED **");
    end
    $finish;
  end

endmodule
